/* hw/rtl/tkc_pkg.sv */
// Shared types and constants for the typed key comparator.
// No dependencies; used by every other file in hw/rtl.
package tkc_pkg;

  localparam int unsigned ELEM_W   = 64;
  localparam int unsigned ORDER_W  = 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic REG_IDX_KIND  = 1'b0;
  localparam logic REG_IDX_WIDTH = 1'b1;

  localparam logic [15:0] SPACE_UNIT = 16'h0020;

  localparam logic [ORDER_W-1:0] ORDER_LT = 2'b11;
  localparam logic [ORDER_W-1:0] ORDER_EQ = 2'b00;
  localparam logic [ORDER_W-1:0] ORDER_GT = 2'b01;
  localparam logic [ORDER_W-1:0] ORDER_BAD = 2'b10;

  typedef enum logic [2:0] {
    KIND_SINT     = 3'd0,
    KIND_UINT     = 3'd1,
    KIND_CHAR     = 3'd2,
    KIND_VARCHAR  = 3'd3,
    KIND_BINARY   = 3'd4,
    KIND_VARBIN   = 3'd5,
    KIND_UCHAR    = 3'd6,
    KIND_UVARCHAR = 3'd7
  } compare_kind_e;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } width_code_e;

  typedef struct packed {
    compare_kind_e kind;
    width_code_e   width;
  } tkc_cfg_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element_a;
    logic [ELEM_W-1:0] element_b;
    logic              a_present;
    logic              b_present;
    logic              last;
  } tkc_item_t;

  typedef struct packed {
    logic               emit;
    logic [ORDER_W-1:0] order;
  } tkc_res_t;

endpackage

/* hw/rtl/tkc_apb_regs.sv */
// APB-style configuration registers: compare kind and integer width.
// Depends on tkc_pkg.
module tkc_apb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkc_pkg::APB_AW-1:0] paddr,
  input  logic [tkc_pkg::APB_DW-1:0] pwdata,
  output logic [tkc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output tkc_pkg::tkc_cfg_t          cfg_o
);

  tkc_pkg::compare_kind_e kind_q, kind_d;
  tkc_pkg::width_code_e   width_q, width_d;
  logic                   wr_en;
  logic                   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[2];

  always_comb begin
    kind_d  = kind_q;
    width_d = width_q;
    if (wr_en) begin
      if (reg_idx == tkc_pkg::REG_IDX_KIND) begin
        kind_d = tkc_pkg::compare_kind_e'(pwdata[2:0]);
      end else begin
        width_d = tkc_pkg::width_code_e'(pwdata[1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= tkc_pkg::KIND_SINT;
      width_q <= tkc_pkg::WIDTH_8;
    end else begin
      kind_q  <= kind_d;
      width_q <= width_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tkc_pkg::REG_IDX_KIND) begin
      prdata[2:0] = kind_q;
    end else begin
      prdata[1:0] = width_q;
    end
  end

  assign cfg_o = '{kind: kind_q, width: width_q};

endmodule

/* hw/rtl/tkc_compare_core.sv */
// Compare logic and sticky string state for one element pair per transaction.
// Depends on tkc_pkg.
module tkc_compare_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tkc_pkg::tkc_cfg_t     cfg_i,
  input  tkc_pkg::tkc_item_t    item_i,
  input  logic                  fire_i,
  output tkc_pkg::tkc_res_t     res_o
);

  logic                          decided_q, decided_d;
  logic [tkc_pkg::ORDER_W-1:0]   dorder_q, dorder_d;

  logic [tkc_pkg::ELEM_W-1:0]    int_mask, int_sign, int_a, int_b;
  logic [tkc_pkg::ORDER_W-1:0]   int_order;
  logic                          is_int, int_signed, is_ucs2, pad_space;
  logic [15:0]                   emask, str_a, str_b;
  logic                          dec_n;
  logic [tkc_pkg::ORDER_W-1:0]   ord_n;

  // integer path
  always_comb begin
    unique case (cfg_i.width)
      tkc_pkg::WIDTH_8:  int_mask = 64'h0000_0000_0000_00FF;
      tkc_pkg::WIDTH_16: int_mask = 64'h0000_0000_0000_FFFF;
      tkc_pkg::WIDTH_32: int_mask = 64'h0000_0000_FFFF_FFFF;
      default:           int_mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    int_sign = int_mask ^ (int_mask >> 1);
    int_a    = (item_i.element_a & int_mask) ^ (int_signed ? int_sign : '0);
    int_b    = (item_i.element_b & int_mask) ^ (int_signed ? int_sign : '0);
    if (int_a < int_b) begin
      int_order = tkc_pkg::ORDER_LT;
    end else if (int_a > int_b) begin
      int_order = tkc_pkg::ORDER_GT;
    end else begin
      int_order = tkc_pkg::ORDER_EQ;
    end
  end

  assign is_int     = (cfg_i.kind == tkc_pkg::KIND_SINT) || (cfg_i.kind == tkc_pkg::KIND_UINT);
  assign int_signed = (cfg_i.kind == tkc_pkg::KIND_SINT);
  assign is_ucs2    = (cfg_i.kind == tkc_pkg::KIND_UCHAR) ||
                      (cfg_i.kind == tkc_pkg::KIND_UVARCHAR);
  assign pad_space  = (cfg_i.kind == tkc_pkg::KIND_VARCHAR) ||
                      (cfg_i.kind == tkc_pkg::KIND_UVARCHAR);
  assign emask      = is_ucs2 ? 16'hFFFF : 16'h00FF;
  assign str_a      = item_i.element_a[15:0] & emask;
  assign str_b      = item_i.element_b[15:0] & emask;

  // string path: first deciding pair sticks
  always_comb begin
    dec_n = decided_q;
    ord_n = dorder_q;
    if (!decided_q) begin
      if (item_i.a_present && item_i.b_present) begin
        if (str_a != str_b) begin
          dec_n = 1'b1;
          ord_n = (str_a < str_b) ? tkc_pkg::ORDER_LT : tkc_pkg::ORDER_GT;
        end
      end else if (item_i.a_present) begin
        if (!pad_space || (str_a != tkc_pkg::SPACE_UNIT)) begin
          dec_n = 1'b1;
          ord_n = tkc_pkg::ORDER_GT;
        end
      end else if (item_i.b_present) begin
        if (!pad_space || (str_b != tkc_pkg::SPACE_UNIT)) begin
          dec_n = 1'b1;
          ord_n = tkc_pkg::ORDER_LT;
        end
      end
    end
  end

  always_comb begin
    res_o.emit  = is_int || item_i.last;
    res_o.order = is_int ? int_order : (dec_n ? ord_n : tkc_pkg::ORDER_EQ);
    decided_d   = decided_q;
    dorder_d    = dorder_q;
    if (fire_i) begin
      if (is_int || item_i.last) begin
        decided_d = 1'b0;
        dorder_d  = tkc_pkg::ORDER_EQ;
      end else begin
        decided_d = dec_n;
        dorder_d  = ord_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q <= 1'b0;
      dorder_q  <= tkc_pkg::ORDER_EQ;
    end else begin
      decided_q <= decided_d;
      dorder_q  <= dorder_d;
    end
  end

endmodule

/* hw/rtl/typed_key_comparator.sv */
// Typed key comparator top level: input register, compare core, result register.
// Depends on tkc_pkg, tkc_apb_regs and tkc_compare_core.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one element pair per
//   transaction: element_a_i, element_b_i, presence flags and last_i.
//   Output channel (out_valid_o/out_ready_i) returns order_o: -1, 0 or +1.
//   Integer kinds give one result per transaction; string kinds give one
//   result on the transaction marked last and none otherwise.
//   An accepted transaction is held in the input register; its result is
//   written to the result register once the output can take it.
//   Throughput: one transaction per cycle while the output is not stalled,
//   with a combinational compare between the two registers; transactions
//   that give no result never wait on the output.
//   A stalled receiver holds the result register; one more result may sit in
//   the input register, after which in_ready_o drops.
//   Reset clears both registers' valid flags, the string state and the
//   configuration (signed 8-bit integers). Configure over APB while idle.
module typed_key_comparator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkc_pkg::APB_AW-1:0] paddr,
  input  logic [tkc_pkg::APB_DW-1:0] pwdata,
  output logic [tkc_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tkc_pkg::ELEM_W-1:0] element_a_i,
  input  logic [tkc_pkg::ELEM_W-1:0] element_b_i,
  input  logic                       a_present_i,
  input  logic                       b_present_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [tkc_pkg::ORDER_W-1:0] order_o
);

  tkc_pkg::tkc_cfg_t            cfg;
  tkc_pkg::tkc_res_t            res;
  tkc_pkg::tkc_item_t           s1_item_q;
  logic                         s1_valid_q, s1_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic [tkc_pkg::ORDER_W-1:0]  out_order_q;
  logic                         in_fire, s1_adv, out_free;

  tkc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tkc_compare_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (s1_item_q),
    .fire_i (s1_adv),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!res.emit || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && res.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= '{element_a: element_a_i, element_b: element_b_i,
                     a_present: a_present_i, b_present: b_present_i, last: last_i};
    end
    if (s1_adv && res.emit) begin
      out_order_q <= res.order;
    end
  end

  assign out_valid_o = out_valid_q;
  assign order_o     = out_order_q;

  a_order_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (order_o != tkc_pkg::ORDER_BAD))
    else $error("illegal order code on output");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  a_fire_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted transaction lost from input register");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && s1_valid_q && res.emit) |-> !in_ready_o)
    else $error("input accepted while result path blocked");

endmodule

/* verif/typed_key_comparator_tb.sv */
`timescale 1ns / 1ps
// Testbench for typed_key_comparator: a directed table, then randomised phases of integer
// and string comparisons under varying back-pressure, each order checked against the model or the table.
// Depends on tkc_pkg and the typed_key_comparator RTL.
module testbench;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 40;
  localparam int DIR_ROWS      = 23;
  localparam logic [tkc_pkg::APB_AW-1:0] ADDR_KIND  = {tkc_pkg::REG_IDX_KIND, 2'b00};
  localparam logic [tkc_pkg::APB_AW-1:0] ADDR_WIDTH = {tkc_pkg::REG_IDX_WIDTH, 2'b00};

  typedef struct {
    tkc_pkg::compare_kind_e      kind;
    tkc_pkg::width_code_e        width;
    logic [tkc_pkg::ELEM_W-1:0]  elem_a;
    logic [tkc_pkg::ELEM_W-1:0]  elem_b;
    logic                        a_pres;
    logic                        b_pres;
    logic                        last;
    bit                          typed;
    logic [tkc_pkg::ORDER_W-1:0] ord;
  } dir_row_t;

  logic                                clk;
  logic                                rst_n     = 1'b0;
  logic                                psel      = 1'b0;
  logic                                penable   = 1'b0;
  logic                                pwrite    = 1'b0;
  logic [tkc_pkg::APB_AW-1:0]          paddr     = '0;
  logic [tkc_pkg::APB_DW-1:0]          pwdata    = '0;
  logic [tkc_pkg::APB_DW-1:0]          prdata;
  logic                                pready;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  logic [tkc_pkg::ELEM_W-1:0]          elem_a    = '0;
  logic [tkc_pkg::ELEM_W-1:0]          elem_b    = '0;
  logic                                a_pres    = 1'b0;
  logic                                b_pres    = 1'b0;
  logic                                last_flag = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b1;
  logic signed [tkc_pkg::ORDER_W-1:0]  result_order;

  tkc_pkg::compare_kind_e      kind_cfg    = tkc_pkg::KIND_SINT;
  tkc_pkg::width_code_e        width_cfg   = tkc_pkg::WIDTH_8;
  bit                          run_decided = 1'b0;
  logic [tkc_pkg::ORDER_W-1:0] run_order   = tkc_pkg::ORDER_EQ;
  logic [tkc_pkg::ORDER_W-1:0] pending_orders [$];
  int                          mismatches     = 0;
  int                          send_idle_pct  = 0;
  int                          recv_stall_pct = 0;
  int                          quiet_cycles   = 0;
  dir_row_t                    dir_rows [DIR_ROWS];

  typed_key_comparator DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .element_a_i (elem_a),
    .element_b_i (elem_b),
    .a_present_i (a_pres),
    .b_present_i (b_pres),
    .last_i      (last_flag),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .order_o     (result_order)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model of one accepted transaction; returns 1 when it yields an order.
  function automatic bit order_for_pair(input logic [tkc_pkg::ELEM_W-1:0] a,
                                        input logic [tkc_pkg::ELEM_W-1:0] b,
                                        input logic ap, input logic bp, input logic last,
                                        output logic [tkc_pkg::ORDER_W-1:0] ord);
    logic [tkc_pkg::ELEM_W-1:0] mask;
    logic [tkc_pkg::ELEM_W-1:0] sgn;
    logic [15:0]                ua;
    logic [15:0]                ub;
    bit                         wide;
    bit                         pad;
    ord = tkc_pkg::ORDER_EQ;
    if (kind_cfg == tkc_pkg::KIND_SINT || kind_cfg == tkc_pkg::KIND_UINT) begin
      case (width_cfg)
        tkc_pkg::WIDTH_8:  mask = 64'h0000_0000_0000_00FF;
        tkc_pkg::WIDTH_16: mask = 64'h0000_0000_0000_FFFF;
        tkc_pkg::WIDTH_32: mask = 64'h0000_0000_FFFF_FFFF;
        default:           mask = '1;
      endcase
      sgn = mask ^ (mask >> 1);
      a &= mask;
      b &= mask;
      if (kind_cfg == tkc_pkg::KIND_SINT) begin
        a ^= sgn;
        b ^= sgn;
      end
      run_decided = 1'b0;
      run_order   = tkc_pkg::ORDER_EQ;
      ord = (a < b) ? tkc_pkg::ORDER_LT : ((a > b) ? tkc_pkg::ORDER_GT : tkc_pkg::ORDER_EQ);
      return 1'b1;
    end
    wide = kind_cfg inside {tkc_pkg::KIND_UCHAR, tkc_pkg::KIND_UVARCHAR};
    pad  = kind_cfg inside {tkc_pkg::KIND_VARCHAR, tkc_pkg::KIND_UVARCHAR};
    ua = wide ? a[15:0] : {8'h00, a[7:0]};
    ub = wide ? b[15:0] : {8'h00, b[7:0]};
    if (!run_decided) begin
      if (ap && bp) begin
        if (ua != ub) begin
          run_decided = 1'b1;
          run_order   = (ua < ub) ? tkc_pkg::ORDER_LT : tkc_pkg::ORDER_GT;
        end
      end else if (ap) begin
        if (!pad || ua != tkc_pkg::SPACE_UNIT) begin
          run_decided = 1'b1;
          run_order   = tkc_pkg::ORDER_GT;
        end
      end else if (bp) begin
        if (!pad || ub != tkc_pkg::SPACE_UNIT) begin
          run_decided = 1'b1;
          run_order   = tkc_pkg::ORDER_LT;
        end
      end
    end
    if (!last) return 1'b0;
    ord = run_decided ? run_order : tkc_pkg::ORDER_EQ;
    run_decided = 1'b0;
    run_order   = tkc_pkg::ORDER_EQ;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_unit(input bit wide);
    case ($urandom_range(9))
      0, 1:    return tkc_pkg::SPACE_UNIT;
      2:       return 16'h0000;
      3:       return wide ? 16'hFFFF : 16'h00FF;
      4:       return wide ? 16'($urandom) : 16'($urandom_range(255));
      default: return 16'h0061 + 16'($urandom_range(2));
    endcase
  endfunction

  // Random upper bits around the unit that the comparison looks at.
  function automatic logic [tkc_pkg::ELEM_W-1:0] dress_unit(input logic [15:0] unit,
                                                            input bit wide);
    logic [tkc_pkg::ELEM_W-1:0] v;
    v = {$urandom, $urandom};
    if (wide) v[15:0] = unit;
    else v[7:0] = unit[7:0];
    return v;
  endfunction

  function automatic logic [tkc_pkg::ELEM_W-1:0] int_edge();
    logic [tkc_pkg::ELEM_W-1:0] sgn;
    sgn = 64'h1 << ((8 << int'(width_cfg)) - 1);
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return sgn;
      default: return sgn - 1;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_pair(input logic [tkc_pkg::ELEM_W-1:0] a,
                           input logic [tkc_pkg::ELEM_W-1:0] b,
                           input logic ap, input logic bp, input logic last,
                           input bit use_typed, input logic [tkc_pkg::ORDER_W-1:0] typed_ord);
    logic [tkc_pkg::ORDER_W-1:0] ord;
    bit                          emitted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    elem_a    <= a;
    elem_b    <= b;
    a_pres    <= ap;
    b_pres    <= bp;
    last_flag <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    emitted = order_for_pair(a, b, ap, bp, last, ord);
    if (use_typed) ord = typed_ord;
    if (emitted) pending_orders.push_back(ord);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_orders.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic [tkc_pkg::APB_AW-1:0] addr,
                           input logic [tkc_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input tkc_pkg::compare_kind_e kind,
                            input tkc_pkg::width_code_e width);
    logic [tkc_pkg::APB_DW-1:0] data;
    quiesce();
    data = $urandom;
    data[2:0] = kind;
    reg_write(ADDR_KIND, data);
    data = $urandom;
    data[1:0] = width;
    reg_write(ADDR_WIDTH, data);
    kind_cfg  = kind;
    width_cfg = width;
  endtask

  task automatic send_integer();
    logic [tkc_pkg::ELEM_W-1:0] a;
    logic [tkc_pkg::ELEM_W-1:0] b;
    a = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       b = a;
      1:       b = a ^ (64'h1 << $urandom_range(63));
      2: begin
        a = int_edge();
        b = int_edge();
      end
      default: b = {$urandom, $urandom};
    endcase
    send_pair(a, b, 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, tkc_pkg::ORDER_EQ);
  endtask

  // One well-formed string comparison; count returns the transactions sent.
  task automatic send_string(output int count);
    int          len_a;
    int          len_b;
    int          span;
    bit          wide;
    bit          pad;
    logic [15:0] ua;
    logic [15:0] ub;
    wide  = kind_cfg inside {tkc_pkg::KIND_UCHAR, tkc_pkg::KIND_UVARCHAR};
    pad   = kind_cfg inside {tkc_pkg::KIND_VARCHAR, tkc_pkg::KIND_UVARCHAR};
    len_a = $urandom_range(6);
    len_b = ($urandom_range(3) == 0) ? len_a : $urandom_range(6);
    span  = (len_a > len_b) ? len_a : len_b;
    if (span == 0) span = 1;
    for (int i = 0; i < span; i++) begin
      if (i < len_a && i < len_b) begin
        ua = pick_unit(wide);
        ub = ($urandom_range(4) == 0) ? pick_unit(wide) : ua;
      end else begin
        ua = (pad && $urandom_range(3) != 0) ? tkc_pkg::SPACE_UNIT : pick_unit(wide);
        ub = (pad && $urandom_range(3) != 0) ? tkc_pkg::SPACE_UNIT : pick_unit(wide);
      end
      send_pair(dress_unit(ua, wide), dress_unit(ub, wide), i < len_a, i < len_b,
                i == span - 1, 1'b0, tkc_pkg::ORDER_EQ);
    end
    count = span;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_orders
    logic [tkc_pkg::ORDER_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_orders.size() == 0) begin
        $display("%0t: order expected none, got %0d", $time, result_order);
        mismatches++;
      end else begin
        want = pending_orders.pop_front();
        if (result_order !== want) begin
          $display("%0t: order expected %0d, got %0d", $time, $signed(want), result_order);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int                     sent;
    int                     count;
    bit                     paused;
    tkc_pkg::compare_kind_e kind;
    tkc_pkg::width_code_e   width;
    dir_rows = '{
      '{tkc_pkg::KIND_SINT, tkc_pkg::WIDTH_8, 64'h80, 64'h7F,
        1'b1, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_LT},
      '{tkc_pkg::KIND_SINT, tkc_pkg::WIDTH_8, 64'hFFFF_FFFF_FFFF_FF7F, 64'h80,
        1'b0, 1'b0, 1'b0, 1'b1, tkc_pkg::ORDER_GT},
      '{tkc_pkg::KIND_UINT, tkc_pkg::WIDTH_64, '1, 64'h0,
        1'b1, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_GT},
      '{tkc_pkg::KIND_UINT, tkc_pkg::WIDTH_64, 64'h0, '1,
        1'b0, 1'b1, 1'b0, 1'b1, tkc_pkg::ORDER_LT},
      '{tkc_pkg::KIND_SINT, tkc_pkg::WIDTH_64, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        1'b1, 1'b0, 1'b1, 1'b1, tkc_pkg::ORDER_LT},
      '{tkc_pkg::KIND_SINT, tkc_pkg::WIDTH_16, 64'hFFFF, 64'hFFFF,
        1'b1, 1'b1, 1'b0, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_SINT, tkc_pkg::WIDTH_32, 64'h1_8000_0000, 64'h0,
        1'b1, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_LT},
      '{tkc_pkg::KIND_UINT, tkc_pkg::WIDTH_8, 64'h1FF, 64'hFF,
        1'b1, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h61, 64'h61,
        1'b1, 1'b1, 1'b0, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h20, 64'h0,
        1'b1, 1'b0, 1'b0, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h120, 64'hFF,
        1'b1, 1'b0, 1'b1, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h62, 64'h61,
        1'b1, 1'b1, 1'b0, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h0, 64'h0,
        1'b0, 1'b0, 1'b1, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARBIN, tkc_pkg::WIDTH_8, 64'h20, 64'h0,
        1'b1, 1'b0, 1'b1, 1'b1, tkc_pkg::ORDER_GT},
      '{tkc_pkg::KIND_VARBIN, tkc_pkg::WIDTH_8, 64'h100, 64'h0,
        1'b1, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_CHAR, tkc_pkg::WIDTH_8, 64'h0, 64'h20,
        1'b0, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_LT},
      '{tkc_pkg::KIND_UVARCHAR, tkc_pkg::WIDTH_8, 64'h0, 64'h1_0020,
        1'b0, 1'b1, 1'b1, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_UCHAR, tkc_pkg::WIDTH_8, 64'hFFFF, 64'h0,
        1'b1, 1'b1, 1'b1, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_BINARY, tkc_pkg::WIDTH_8, 64'h00, 64'hFF,
        1'b1, 1'b1, 1'b0, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_BINARY, tkc_pkg::WIDTH_8, 64'hFF, 64'h00,
        1'b1, 1'b1, 1'b1, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_UVARCHAR, tkc_pkg::WIDTH_8, 64'h0, 64'h0,
        1'b0, 1'b0, 1'b1, 1'b1, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h41, 64'h41,
        1'b1, 1'b1, 1'b0, 1'b0, tkc_pkg::ORDER_EQ},
      '{tkc_pkg::KIND_VARCHAR, tkc_pkg::WIDTH_8, 64'h0, 64'h5A,
        1'b0, 1'b1, 1'b1, 1'b0, tkc_pkg::ORDER_EQ}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, no idling
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind != kind_cfg || dir_rows[i].width != width_cfg)
        set_config(dir_rows[i].kind, dir_rows[i].width);
      send_pair(dir_rows[i].elem_a, dir_rows[i].elem_b, dir_rows[i].a_pres,
                dir_rows[i].b_pres, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].ord);
    end

    paused = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      kind  = (p < 8) ? tkc_pkg::compare_kind_e'(p)
                      : tkc_pkg::compare_kind_e'($urandom_range(7));
      width = (p == 0) ? tkc_pkg::WIDTH_8
                       : ((p == 1) ? tkc_pkg::WIDTH_64
                                   : tkc_pkg::width_code_e'($urandom_range(3)));
      set_config(kind, width);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct  = 29;
          recv_stall_pct = 29;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
          quiesce();
          paused = 1'b1;
        end
        if (kind_cfg == tkc_pkg::KIND_SINT || kind_cfg == tkc_pkg::KIND_UINT) begin
          send_integer();
          sent++;
        end else if ($urandom_range(9) == 0) begin
          // stray transaction with arbitrary flags
          send_pair({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom),
                    1'($urandom), 1'($urandom), 1'b0, tkc_pkg::ORDER_EQ);
          sent++;
        end else begin
          send_string(count);
          sent += count;
        end
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
